// ===== rtl/nfrc_pkg.sv =====
// Shared constants, register codes and saturating arithmetic for the Newton root classifier.
package nfrc_pkg;

  localparam int MAX_ROOTS_DEF  = 5;
  localparam int FRAC_BITS_DEF  = 24;
  localparam int NUM_ROOT_REGS  = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int COORD_W        = 32;
  localparam int ROOT_IDX_W     = 3;
  localparam int ITER_W         = 16;
  localparam int THRESH_W       = 63;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROOTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_SQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_A    = 3'd3;

  localparam logic [2:0]          NUM_ROOTS_RST = 3'd5;
  localparam logic [ITER_W-1:0]   MAX_ITER_RST  = 16'd10;
  localparam logic [THRESH_W-1:0] THRESH_RST    = 63'd3;
  localparam logic [63:0] ROOT_A_RST = 64'h0100_0000_0000_0000;
  localparam logic [63:0] ROOT_B_RST = 64'h0000_0000_0100_0000;
  localparam logic [63:0] ROOT_C_RST = 64'hFF00_0000_0000_0000;
  localparam logic [63:0] ROOT_D_RST = 64'h0000_0000_FF00_0000;
  localparam logic [63:0] ROOT_E_RST = 64'h0000_0000_0000_0000;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0001;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    else if (s < 65'(SMIN)) return SMIN;
    else return $signed(s[63:0]);
  endfunction

endpackage

// ===== rtl/nfrc_if.sv =====
// Valid/ready item channels for start points and classification results.
interface nfrc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [nfrc_pkg::COORD_W-1:0]    start_re;
  logic signed [nfrc_pkg::COORD_W-1:0]    start_im;
  modport source (output valid, output start_re, output start_im, input ready);
  modport sink (input valid, input start_re, input start_im, output ready);
endinterface

interface nfrc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [nfrc_pkg::ROOT_IDX_W-1:0]      root_index;
  logic [nfrc_pkg::ITER_W-1:0]          iter_count;
  modport source (output valid, output root_index, output iter_count, input ready);
  modport sink (input valid, input root_index, input iter_count, output ready);
endinterface

// ===== rtl/nfrc_mulq.sv =====
// Shared 64x64 signed fixed-point multiplier built from four 32x32 partial products.
module nfrc_mulq #(
  parameter int FRAC_BITS = nfrc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] q_o,
  output logic [63:0]        lo_o
);

  localparam int P = 2 * FRAC_BITS;
  localparam logic [63:0] SMAX_U = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [63:0]  am_q, bm_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [1:0]   cnt_q;
  logic         busy_q, done_q;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  rl, mag_sat;

  assign a_half = cnt_q[1] ? am_q[63:32] : am_q[31:0];
  assign b_half = cnt_q[0] ? bm_q[63:32] : bm_q[31:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (cnt_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      2'd2:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  assign rl      = acc_q[P+63:P];
  assign mag_sat = ((|acc_q[127:P+64]) || rl[63]) ? 64'(SMAX_U) : rl;
  assign q_o     = neg_q ? -$signed(mag_sat) : $signed(mag_sat);
  assign lo_o    = acc_q[63:0];
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= nfrc_pkg::mag64(a_i);
      bm_q  <= nfrc_pkg::mag64(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

endmodule

// ===== rtl/newton_fractal_root_classifier_top.sv =====
// Newton root classifier: sequencer around a shared multiplier and a radix-2 divider.
// Each 64x64 product runs on the shared 32x32 multiplier and each quotient part
//   on the bit-serial divider.
// Throughput: one item at a time; ready only when idle, a finished result waits
//   in the output register. Reset: registers return to 1, i, -1, -i, 0 roots.
module newton_fractal_root_classifier_top #(
  parameter int MAX_ROOTS = nfrc_pkg::MAX_ROOTS_DEF,
  parameter int FRAC_BITS = nfrc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nfrc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nfrc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  nfrc_in_if.sink                           in_i,
  nfrc_out_if.source                        out_o
);

  localparam int P  = 2 * FRAC_BITS;
  localparam int KW = $clog2(MAX_ROOTS + 1);
  localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);
  localparam logic signed [63:0] ONE_P = 64'sd1 <<< P;

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_ITER    = 17'h00002,
    S_RDIFF   = 17'h00004,
    S_RMUL    = 17'h00008,
    S_RWAIT   = 17'h00010,
    S_RUPD    = 17'h00020,
    S_NMUL    = 17'h00040,
    S_NWAIT   = 17'h00080,
    S_NDEN    = 17'h00100,
    S_DIVINIT = 17'h00200,
    S_DIV     = 17'h00400,
    S_DIVFIN  = 17'h00800,
    S_ZUPD    = 17'h01000,
    S_CHKD    = 17'h02000,
    S_CMUL    = 17'h04000,
    S_CWAIT   = 17'h08000,
    S_OUT     = 17'h10000
  } state_e;

  state_e state_q;

  // configuration
  logic [2:0]                   num_roots_q;
  logic [nfrc_pkg::ITER_W-1:0]  max_iter_q;
  logic [nfrc_pkg::THRESH_W-1:0] thresh_q;
  logic [63:0]                  roots_q [nfrc_pkg::NUM_ROOT_REGS];

  // datapath
  logic signed [31:0] zr_q, zi_q;
  logic signed [63:0] p_re_q, p_im_q, dp_re_q, dp_im_q, d_re_q, d_im_q;
  logic signed [63:0] acc_q [4];
  logic [2:0]         j_q;
  logic [KW-1:0]      k_q;
  logic [nfrc_pkg::ITER_W-1:0] it_q;
  logic [63:0]        rem_q, dlo_q, quo_q;
  logic [5:0]         dcnt_q;
  logic               dneg_q, dsel_q;
  logic signed [63:0] rnd_q;
  logic [32:0]        ax_q, ay_q;
  logic [63:0]        sx_q;
  logic [nfrc_pkg::ROOT_IDX_W-1:0] res_idx_q, out_idx_q;
  logic [nfrc_pkg::ITER_W-1:0]     res_iter_q, out_iter_q;
  logic               out_valid_q;

  // combinational
  logic [KW-1:0]      nr;
  logic [3:0]         k_ext;
  logic [63:0]        root_w;
  logic signed [31:0] rr, ri;
  logic signed [32:0] dx, dy;
  logic               mul_start, mul_done;
  logic signed [63:0] mul_a, mul_b, mul_q, mul_v;
  logic [63:0]        mul_lo;
  logic               mul_neg;
  logic signed [63:0] div_n;
  logic [63:0]        div_m, div_hi, div_lo, den_u;
  logic [64:0]        r2, r2_sub;
  logic               r2_ge;
  logic [63:0]        qm, rm;
  logic signed [63:0] zsub;
  logic signed [31:0] zsat;
  logic [64:0]        dsum;
  logic [63:0]        dsum_sat;
  logic               out_load;

  assign nr = ({1'b0, num_roots_q} > 4'(MAX_ROOTS)) ? KW'(MAX_ROOTS) : KW'(num_roots_q);

  assign k_ext  = 4'(k_q);
  assign root_w = (k_ext < 4'(nfrc_pkg::NUM_ROOT_REGS)) ? roots_q[k_ext[2:0]] : 64'd0;
  assign rr     = $signed(root_w[63:32]);
  assign ri     = $signed(root_w[31:0]);
  assign dx     = 33'(zr_q) - 33'(rr);
  assign dy     = 33'(zi_q) - 33'(ri);

  always_comb begin
    mul_a = dp_re_q;
    mul_b = d_re_q;
    case (state_q)
      S_RMUL: begin
        case (j_q)
          3'd0:    begin mul_a = dp_re_q; mul_b = d_re_q; end
          3'd1:    begin mul_a = dp_im_q; mul_b = d_im_q; end
          3'd2:    begin mul_a = dp_re_q; mul_b = d_im_q; end
          3'd3:    begin mul_a = dp_im_q; mul_b = d_re_q; end
          3'd4:    begin mul_a = p_re_q;  mul_b = d_re_q; end
          3'd5:    begin mul_a = p_im_q;  mul_b = d_im_q; end
          3'd6:    begin mul_a = p_re_q;  mul_b = d_im_q; end
          default: begin mul_a = p_im_q;  mul_b = d_re_q; end
        endcase
      end
      S_NMUL: begin
        case (j_q)
          3'd0:    begin mul_a = dp_re_q; mul_b = dp_re_q; end
          3'd1:    begin mul_a = dp_im_q; mul_b = dp_im_q; end
          3'd2:    begin mul_a = p_re_q;  mul_b = dp_re_q; end
          3'd3:    begin mul_a = p_im_q;  mul_b = dp_im_q; end
          3'd4:    begin mul_a = p_im_q;  mul_b = dp_re_q; end
          default: begin mul_a = p_re_q;  mul_b = dp_im_q; end
        endcase
      end
      S_CMUL: begin
        mul_a = j_q[0] ? $signed(64'(ay_q)) : $signed(64'(ax_q));
        mul_b = mul_a;
      end
      default: begin
        mul_a = dp_re_q;
        mul_b = d_re_q;
      end
    endcase
  end

  assign mul_start = (state_q == S_RMUL) || (state_q == S_NMUL) || (state_q == S_CMUL);
  assign mul_neg   = ((state_q == S_RWAIT) && ((j_q == 3'd1) || (j_q == 3'd5))) ||
                     ((state_q == S_NWAIT) && (j_q == 3'd5));
  assign mul_v     = mul_neg ? -mul_q : mul_q;

  nfrc_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .q_o     (mul_q),
    .lo_o    (mul_lo)
  );

  // divider
  assign div_n  = dsel_q ? acc_q[2] : acc_q[1];
  assign div_m  = nfrc_pkg::mag64(div_n);
  assign div_hi = div_m >> (64 - P);
  assign div_lo = div_m << P;
  assign den_u  = acc_q[0];
  assign r2     = {rem_q, dlo_q[63]};
  assign r2_ge  = r2 >= {1'b0, den_u};
  assign r2_sub = r2 - {1'b0, den_u};

  assign qm   = quo_q[63] ? 64'(nfrc_pkg::SMAX) : quo_q;
  assign rm   = (qm + HALF) >> FRAC_BITS;
  assign zsub = (dsel_q ? 64'(zi_q) : 64'(zr_q)) - rnd_q;
  assign zsat = (zsub > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                (zsub < -64'sd2147483648) ? 32'sh8000_0000 : zsub[31:0];

  assign dsum     = {1'b0, sx_q} + {1'b0, mul_lo};
  assign dsum_sat = dsum[64] ? {64{1'b1}} : dsum[63:0];

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.root_index = out_idx_q;
  assign out_o.iter_count = out_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_roots_q <= nfrc_pkg::NUM_ROOTS_RST;
      max_iter_q  <= nfrc_pkg::MAX_ITER_RST;
      thresh_q    <= nfrc_pkg::THRESH_RST;
      roots_q[0]  <= nfrc_pkg::ROOT_A_RST;
      roots_q[1]  <= nfrc_pkg::ROOT_B_RST;
      roots_q[2]  <= nfrc_pkg::ROOT_C_RST;
      roots_q[3]  <= nfrc_pkg::ROOT_D_RST;
      roots_q[4]  <= nfrc_pkg::ROOT_E_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nfrc_pkg::REG_NUM_ROOTS: num_roots_q <= cfg_data_i[2:0];
        nfrc_pkg::REG_MAX_ITER:  max_iter_q  <= cfg_data_i[15:0];
        nfrc_pkg::REG_THRESH_SQ: thresh_q    <= cfg_data_i[62:0];
        default: roots_q[3'(cfg_idx_i - nfrc_pkg::REG_ROOT_A)] <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      j_q         <= 3'd0;
      k_q         <= '0;
      it_q        <= '0;
      dcnt_q      <= 6'd0;
      dsel_q      <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            it_q    <= 16'd1;
            state_q <= S_ITER;
          end
        end
        S_ITER: begin
          k_q <= '0;
          if (it_q >= max_iter_q) state_q <= S_OUT;
          else state_q <= S_RDIFF;
        end
        S_RDIFF: begin
          j_q <= 3'd0;
          if (k_q == nr) state_q <= S_NMUL;
          else state_q <= S_RMUL;
        end
        S_RMUL: state_q <= S_RWAIT;
        S_RWAIT: begin
          if (mul_done) begin
            j_q <= j_q + 3'd1;
            if (j_q == 3'd7) state_q <= S_RUPD;
            else state_q <= S_RMUL;
          end
        end
        S_RUPD: begin
          k_q     <= k_q + KW'(1);
          state_q <= S_RDIFF;
        end
        S_NMUL: state_q <= S_NWAIT;
        S_NWAIT: begin
          if (mul_done) begin
            j_q <= j_q + 3'd1;
            if (j_q == 3'd5) state_q <= S_NDEN;
            else state_q <= S_NMUL;
          end
        end
        S_NDEN: begin
          dsel_q <= 1'b0;
          if (acc_q[0] <= 64'sd0) state_q <= S_OUT;
          else state_q <= S_DIVINIT;
        end
        S_DIVINIT: begin
          dcnt_q <= 6'd0;
          if (div_hi >= den_u) state_q <= S_DIVFIN;
          else state_q <= S_DIV;
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd63) state_q <= S_DIVFIN;
        end
        S_DIVFIN: state_q <= S_ZUPD;
        S_ZUPD: begin
          k_q <= '0;
          if (!dsel_q) begin
            dsel_q  <= 1'b1;
            state_q <= S_DIVINIT;
          end else begin
            state_q <= S_CHKD;
          end
        end
        S_CHKD: begin
          j_q <= 3'd0;
          if (k_q == nr) begin
            it_q    <= it_q + 16'd1;
            state_q <= S_ITER;
          end else begin
            state_q <= S_CMUL;
          end
        end
        S_CMUL: state_q <= S_CWAIT;
        S_CWAIT: begin
          if (mul_done) begin
            if (j_q == 3'd0) begin
              j_q     <= 3'd1;
              state_q <= S_CMUL;
            end else if (dsum_sat < {1'b0, thresh_q}) begin
              state_q <= S_OUT;
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_CHKD;
            end
          end
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        zr_q <= in_i.start_re;
        zi_q <= in_i.start_im;
      end
      S_ITER: begin
        p_re_q     <= ONE_P;
        p_im_q     <= 64'sd0;
        dp_re_q    <= 64'sd0;
        dp_im_q    <= 64'sd0;
        res_idx_q  <= 3'(nr);
        res_iter_q <= max_iter_q;
      end
      S_RDIFF: begin
        d_re_q <= 64'(dx) <<< FRAC_BITS;
        d_im_q <= 64'(dy) <<< FRAC_BITS;
      end
      S_RWAIT, S_NWAIT: begin
        if (mul_done) begin
          if (!j_q[0]) acc_q[j_q[2:1]] <= mul_q;
          else acc_q[j_q[2:1]] <= nfrc_pkg::sat_add(acc_q[j_q[2:1]], mul_v);
        end
      end
      S_RUPD: begin
        dp_re_q <= nfrc_pkg::sat_add(acc_q[0], p_re_q);
        dp_im_q <= nfrc_pkg::sat_add(acc_q[1], p_im_q);
        p_re_q  <= acc_q[2];
        p_im_q  <= acc_q[3];
      end
      S_DIVINIT: begin
        dneg_q <= div_n[63];
        rem_q  <= div_hi;
        dlo_q  <= div_lo;
        quo_q  <= (div_hi >= den_u) ? 64'(nfrc_pkg::SMAX) : 64'd0;
      end
      S_DIV: begin
        rem_q <= r2_ge ? r2_sub[63:0] : r2[63:0];
        dlo_q <= {dlo_q[62:0], 1'b0};
        quo_q <= {quo_q[62:0], r2_ge};
      end
      S_DIVFIN: rnd_q <= dneg_q ? -$signed(rm) : $signed(rm);
      S_ZUPD: begin
        if (!dsel_q) zr_q <= zsat;
        else zi_q <= zsat;
      end
      S_CHKD: begin
        ax_q <= dx[32] ? 33'(-dx) : 33'(dx);
        ay_q <= dy[32] ? 33'(-dy) : 33'(dy);
      end
      S_CWAIT: begin
        if (mul_done) begin
          if (j_q == 3'd0) sx_q <= mul_lo;
          else if (dsum_sat < {1'b0, thresh_q}) begin
            res_idx_q  <= 3'(k_q);
            res_iter_q <= it_q;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_idx_q  <= res_idx_q;
          out_iter_q <= res_iter_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
